### hdl/timed_slot_pool_evict_oldest_core_macros.svh
// ----------------------------------------------------------------------------
// timed slot pool assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TIMED_SLOT_POOL_EVICT_OLDEST_CORE_MACROS_SVH
`define TIMED_SLOT_POOL_EVICT_OLDEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define TSP_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define TSP_ASSERT_IMP(lbl, a, b)
`define TSP_ASSERT_NXT(lbl, a, b)
`endif
`endif

### hdl/tspeo_pkg.sv
// ----------------------------------------------------------------------------
// tspeo_pkg
// transaction types and codes of the timed slot pool
// ----------------------------------------------------------------------------
package tspeo_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_REL   = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EVICT   = 3'd1;
	localparam logic [2:0] ST_EXPIRED = 3'd2;
	localparam logic [2:0] ST_NONE    = 3'd3;
	localparam logic [2:0] ST_BAD_REL = 3'd4;

	localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LIFE_RESET = 16'd1000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  slot_index;
		logic [2:0]  effect_type;
		logic [30:0] now_time;
	} in_t;

	typedef struct packed {
		logic [5:0] result_slot;
		logic [2:0] status;
		logic [6:0] active_count;
		logic       last_result;
	} out_t;

endpackage

### hdl/timed_slot_pool_evict_oldest_core.sv
// allocate evicts the oldest slot first when the pool is full; a sweep visits
// each active slot from the oldest and frees the expired ones; results can stall it
// one transaction at a time; all steps share one read port per slot memory
// throughput: a new transaction is taken once the previous one has put its
// last result in the output register
// reset: asynchronous, all slots free, lifetime 1000, output empty
// ----------------------------------------------------------------------------
// timed_slot_pool_evict_oldest_core
// slot pool with lifo free stack, age-ordered active list and expiry sweep
// ----------------------------------------------------------------------------
`include "timed_slot_pool_evict_oldest_core_macros.svh"

module timed_slot_pool_evict_oldest_core
	import tspeo_pkg::*;
#(
	parameter int POOL_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int TW = $clog2(POOL_SLOTS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_UNRD  = 4'd1;
	localparam logic [3:0] S_UNWR  = 4'd2;
	localparam logic [3:0] S_ACHK  = 4'd3;
	localparam logic [3:0] S_ARD   = 4'd4;
	localparam logic [3:0] S_AWR   = 4'd5;
	localparam logic [3:0] S_RDONE = 4'd6;
	localparam logic [3:0] S_WRD   = 4'd7;
	localparam logic [3:0] S_WCHK  = 4'd8;
	localparam logic [3:0] S_WHIT  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0]            state_q, ret_q;
	logic [15:0]           life_q;
	logic [POOL_SLOTS-1:0] active_q, stk_init_q;
	logic [TW-1:0]         free_top_q, count_q, visit_q;
	logic [5:0]            oldest_q, newest_q;
	logic [AW-1:0]         s_q, cur_q, nxt_q;
	logic [5:0]            idx_q;
	logic [30:0]           now_q;
	logic [2:0]            status_q;
	logic                  pend_valid_q;
	logic [5:0]            pend_slot_q;
	logic [2:0]            pend_status_q;
	logic [6:0]            pend_cnt_q;
	logic                  out_valid_q;
	out_t                  out_q;

	// slot memories
	logic [30:0] end_mem [POOL_SLOTS];
	logic [5:0]  newer_mem [POOL_SLOTS];
	logic [5:0]  older_mem [POOL_SLOTS];
	logic [5:0]  stack_mem [POOL_SLOTS];
	logic [30:0] end_rd_q;
	logic [5:0]  newer_rd_q, older_rd_q, stack_rd_q;

	logic [AW-1:0] rd_addr;
	logic          newer_we, older_we, end_we, stk_we;
	logic [AW-1:0] newer_wa, older_wa, end_wa, stk_wa;
	logic [5:0]    newer_wd, older_wd, stk_wd;
	logic [31:0]   end_sum;
	logic [30:0]   end_sat;
	logic [5:0]    s6;
	logic [AW-1:0] alloc_s;
	logic [TW-1:0] ft_m1;
	logic          accept, can_emit, hit, rel_ok, full;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign can_emit = !out_valid_q || out_ready;
	assign s6       = 6'(s_q);
	assign alloc_s  = stack_rd_q[AW-1:0];
	assign ft_m1    = free_top_q - 1'b1;
	assign full     = (free_top_q >= TW'(POOL_SLOTS));
	assign end_sum  = {1'b0, now_q} + {16'd0, life_q};
	assign end_sat  = end_sum[31] ? TIME_MAX : end_sum[30:0];
	assign hit      = active_q[cur_q] && (now_q >= end_rd_q);
	assign rel_ok   = (7'(in_data.slot_index) < 7'(POOL_SLOTS))
		&& active_q[in_data.slot_index[AW-1:0]];

	always_comb begin
		case (state_q)
			S_ARD:   rd_addr = free_top_q[AW-1:0];
			S_WRD,
			S_WCHK:  rd_addr = cur_q;
			default: rd_addr = s_q;
		endcase
	end

	always_comb begin
		newer_we = 1'b0;
		newer_wa = older_rd_q[AW-1:0];
		newer_wd = newer_rd_q;
		older_we = 1'b0;
		older_wa = newer_rd_q[AW-1:0];
		older_wd = older_rd_q;
		end_we   = 1'b0;
		end_wa   = alloc_s;
		stk_we   = 1'b0;
		stk_wa   = ft_m1[AW-1:0];
		stk_wd   = s6;
		case (state_q)
			S_UNWR: begin
				newer_we = (s6 != oldest_q);
				older_we = (s6 != newest_q);
				stk_we   = (free_top_q != '0);
			end
			S_AWR: begin
				end_we = 1'b1;
				if (count_q != '0) begin
					newer_we = 1'b1;
					newer_wa = newest_q[AW-1:0];
					newer_wd = 6'(alloc_s);
					older_we = 1'b1;
					older_wa = alloc_s;
					older_wd = newest_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (newer_we) newer_mem[newer_wa] <= newer_wd;
		if (older_we) older_mem[older_wa] <= older_wd;
		if (end_we)   end_mem[end_wa] <= end_sat;
		if (stk_we)   stack_mem[stk_wa] <= stk_wd;
		newer_rd_q <= newer_mem[rd_addr];
		older_rd_q <= older_mem[rd_addr];
		end_rd_q   <= end_mem[rd_addr];
		stack_rd_q <= stk_init_q[rd_addr] ? stack_mem[rd_addr] : 6'(rd_addr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			life_q       <= LIFE_RESET;
			active_q     <= '0;
			stk_init_q   <= '0;
			free_top_q   <= '0;
			count_q      <= '0;
			visit_q      <= '0;
			oldest_q     <= '0;
			newest_q     <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_we) life_q <= cfg_data;
			if (stk_we) stk_init_q[stk_wa] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q        <= in_data.slot_index;
						now_q        <= in_data.now_time;
						pend_valid_q <= 1'b0;
						status_q     <= ST_OK;
						case (in_data.opcode)
							OP_ALLOC: begin
								if (full) begin
									status_q <= ST_EVICT;
									if (count_q != '0) begin
										s_q     <= oldest_q[AW-1:0];
										ret_q   <= S_ACHK;
										state_q <= S_UNRD;
									end
								end else begin
									state_q <= S_ARD;
								end
							end
							OP_REL: begin
								if (rel_ok) begin
									s_q     <= in_data.slot_index[AW-1:0];
									ret_q   <= S_RDONE;
									state_q <= S_UNRD;
								end else begin
									pend_valid_q  <= 1'b1;
									pend_slot_q   <= in_data.slot_index;
									pend_status_q <= ST_BAD_REL;
									pend_cnt_q    <= 7'(count_q);
									state_q       <= S_FIN;
								end
							end
							OP_SWEEP: begin
								cur_q   <= oldest_q[AW-1:0];
								visit_q <= count_q;
								state_q <= (count_q == '0) ? S_FIN : S_WRD;
							end
							default: ;
						endcase
					end
				end
				S_UNRD: state_q <= S_UNWR;
				S_UNWR: begin
					if (s6 == oldest_q) oldest_q <= newer_rd_q;
					if (s6 == newest_q) newest_q <= older_rd_q;
					active_q[s_q] <= 1'b0;
					if (free_top_q != '0) free_top_q <= ft_m1;
					if (count_q != '0) count_q <= count_q - 1'b1;
					state_q <= ret_q;
				end
				S_ACHK: state_q <= full ? S_IDLE : S_ARD;
				S_ARD:  state_q <= S_AWR;
				S_AWR: begin
					if (count_q == '0) oldest_q <= 6'(alloc_s);
					newest_q          <= 6'(alloc_s);
					active_q[alloc_s] <= 1'b1;
					count_q           <= count_q + 1'b1;
					free_top_q        <= free_top_q + 1'b1;
					pend_valid_q      <= 1'b1;
					pend_slot_q       <= 6'(alloc_s);
					pend_status_q     <= status_q;
					pend_cnt_q        <= 7'(count_q + 1'b1);
					state_q           <= S_FIN;
				end
				S_RDONE: begin
					pend_valid_q  <= 1'b1;
					pend_slot_q   <= idx_q;
					pend_status_q <= ST_OK;
					pend_cnt_q    <= 7'(count_q);
					state_q       <= S_FIN;
				end
				S_WRD: state_q <= S_WCHK;
				S_WCHK: begin
					if (hit) begin
						// previous freed slot goes out first, not the last one
						if (!pend_valid_q || can_emit) begin
							nxt_q   <= newer_rd_q[AW-1:0];
							s_q     <= cur_q;
							ret_q   <= S_WHIT;
							state_q <= S_UNRD;
						end
					end else begin
						cur_q   <= newer_rd_q[AW-1:0];
						visit_q <= visit_q - 1'b1;
						state_q <= (visit_q == TW'(1)) ? S_FIN : S_WRD;
					end
				end
				S_WHIT: begin
					pend_valid_q  <= 1'b1;
					pend_slot_q   <= s6;
					pend_status_q <= ST_EXPIRED;
					pend_cnt_q    <= 7'(count_q);
					cur_q         <= nxt_q;
					visit_q       <= visit_q - 1'b1;
					state_q       <= (visit_q == TW'(1)) ? S_FIN : S_WRD;
				end
				S_FIN: begin
					if (can_emit) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_WCHK && hit && pend_valid_q && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			if (state_q == S_FIN) begin
				if (pend_valid_q) begin
					out_q <= '{pend_slot_q, pend_status_q, pend_cnt_q, 1'b1};
				end else begin
					out_q <= '{6'd0, ST_NONE, 7'(count_q), 1'b1};
				end
			end else if (state_q == S_WCHK && hit && pend_valid_q) begin
				out_q <= '{pend_slot_q, pend_status_q, pend_cnt_q, 1'b0};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TSP_ASSERT_IMP(a_top_tracks_count, 1'b1, free_top_q == count_q)
	`TSP_ASSERT_IMP(a_idle_no_pending, state_q == S_IDLE, !pend_valid_q)
	`TSP_ASSERT_NXT(a_fin_emits, (state_q == S_FIN) && can_emit, out_valid_q && out_q.last_result)

endmodule

### tb/tspeo_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspeo_scoreboard
// watches both channels of the slot pool, predicts every result from a model
// of the free stack and age list, and compares each result field by field
// ----------------------------------------------------------------------------
module tspeo_scoreboard
	import tspeo_pkg::*;
#(
	parameter int POOL_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output int          err_count,
	output int          pending
);

	logic [15:0] life;
	logic        active [64];
	logic [30:0] end_at [64];
	logic [5:0]  stack [64];
	int          top;
	logic [5:0]  newer [64];
	logic [5:0]  older [64];
	logic [5:0]  oldest;
	logic [5:0]  newest;
	int          n_active;
	out_t        results_due [$];

	assign pending = results_due.size();

	function automatic void pool_clear();
		life = LIFE_RESET;
		for (int i = 0; i < 64; i++) begin
			active[i] = 1'b0;
			end_at[i] = '0;
			stack[i] = 6'(i);
			newer[i] = '0;
			older[i] = '0;
		end
		top = 0;
		oldest = '0;
		newest = '0;
		n_active = 0;
	endfunction

	function automatic void free_slot(logic [5:0] s);
		logic [5:0] o;
		logic [5:0] n;
		o = older[s];
		n = newer[s];
		if (s == oldest) oldest = n;
		else newer[o] = n;
		if (s == newest) newest = o;
		else older[n] = o;
		active[s] = 1'b0;
		if (top > 0) begin
			top--;
			stack[top] = s;
		end
		if (n_active > 0) n_active--;
	endfunction

	function automatic void push_result(logic [5:0] s, logic [2:0] st, logic last);
		out_t r;
		r.result_slot = s;
		r.status = st;
		r.active_count = 7'(n_active);
		r.last_result = last;
		results_due.push_back(r);
	endfunction

	function automatic void predict_pool(in_t t);
		logic [2:0]  st;
		logic [5:0]  s;
		logic [5:0]  cur;
		logic [5:0]  nxt;
		logic [31:0] sum;
		int          visits;
		int          freed;
		case (t.opcode)
			OP_ALLOC: begin
				st = ST_OK;
				if (top >= POOL_SLOTS) begin
					if (n_active > 0) free_slot(oldest);
					st = ST_EVICT;
				end
				if (top < POOL_SLOTS) begin
					s = stack[top];
					top++;
					sum = {1'b0, t.now_time} + {16'd0, life};
					end_at[s] = sum[31] ? TIME_MAX : sum[30:0];
					if (n_active == 0) begin
						oldest = s;
						newest = s;
					end else begin
						newer[newest] = s;
						older[s] = newest;
						newest = s;
					end
					active[s] = 1'b1;
					n_active++;
					push_result(s, st, 1'b1);
				end
			end
			OP_REL: begin
				if (t.slot_index >= POOL_SLOTS || !active[t.slot_index]) begin
					push_result(t.slot_index, ST_BAD_REL, 1'b1);
				end else begin
					free_slot(t.slot_index);
					push_result(t.slot_index, ST_OK, 1'b1);
				end
			end
			OP_SWEEP: begin
				visits = n_active;
				cur = oldest;
				freed = 0;
				for (int i = 0; i < visits && i < POOL_SLOTS; i++) begin
					nxt = newer[cur];
					if (active[cur] && t.now_time >= end_at[cur]) begin
						free_slot(cur);
						push_result(cur, ST_EXPIRED, 1'b0);
						freed++;
					end
					cur = nxt;
				end
				if (freed == 0) push_result('0, ST_NONE, 1'b1);
				else results_due[$].last_result = 1'b1;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			pool_clear();
			results_due.delete();
			err_count <= 0;
		end else begin
			if (cfg_we) life = cfg_data;
			// result check first: the input handshake cannot add to this transaction
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t unexpected result: actual %p", $time, out_data);
					err_count <= err_count + 1;
				end else begin
					want = results_due.pop_front();
					if (want.result_slot !== out_data.result_slot
							|| want.status !== out_data.status
							|| want.active_count !== out_data.active_count
							|| want.last_result !== out_data.last_result) begin
						$display("%0t result mismatch: expected %p actual %p",
							$time, want, out_data);
						err_count <= err_count + 1;
					end
				end
			end
			if (in_valid && in_ready) predict_pool(in_data);
		end
	end

endmodule

### tb/tb_timed_slot_pool_evict_oldest_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_slot_pool_evict_oldest_core
// directed and random allocate, release and sweep traffic with random stalls
// on both channels, several lifetime settings, verdict from the scoreboard
// ----------------------------------------------------------------------------
module tb_timed_slot_pool_evict_oldest_core;
	import tspeo_pkg::*;

	localparam int SLOTS = 32;
	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	int          err_count;
	int          pending;

	int          send_gap_pct = 0;
	int          recv_gap_pct = 0;
	bit          hold_off = 1'b0;
	int          quiet_cycles = 0;
	logic [30:0] clock_now = '0;

	always #5 clk = ~clk;

	timed_slot_pool_evict_oldest_core #(.POOL_SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	tspeo_scoreboard #(.POOL_SLOTS(SLOTS)) u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.err_count(err_count), .pending(pending)
	);

	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// valid stays up after a transaction until the next gap or drain
	task automatic send_op(logic [1:0] op, logic [5:0] idx, logic [2:0] kind,
			logic [30:0] t);
		in_t item;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		item.opcode = op;
		item.slot_index = idx;
		item.effect_type = kind;
		item.now_time = t;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_life(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed: allocations, releases and sweeps on an advancing clock
	task automatic random_ops(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			clock_now = clock_now + 31'($urandom_range(40));
			if (pick < 45)
				send_op(OP_ALLOC, 6'($urandom), 3'($urandom), clock_now);
			else if (pick < 70)
				send_op(OP_REL, ($urandom_range(9) == 0) ? 6'($urandom)
					: 6'($urandom_range(SLOTS - 1)), 3'($urandom), 31'($urandom));
			else if (pick < 95)
				send_op(OP_SWEEP, 6'($urandom), 3'($urandom),
					($urandom_range(19) == 0) ? 31'($urandom) : clock_now);
			else
				send_op(2'd3, 6'($urandom), 3'($urandom), 31'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default lifetime with releases and sweeps, then maximum lifetime past capacity
		send_op(OP_SWEEP, '0, '0, '0);
		send_op(OP_ALLOC, 6'd63, 3'd0, 31'd0);
		send_op(OP_ALLOC, '0, 3'd5, TIME_MAX);
		send_op(OP_ALLOC, '0, 3'd7, 31'd500);
		send_op(OP_REL, 6'd1, '0, '0);
		send_op(OP_REL, 6'd1, '0, '0);
		send_op(OP_REL, 6'd63, '0, '0);
		send_op(2'd3, 6'h3F, 3'd7, TIME_MAX);
		send_op(OP_SWEEP, '0, '0, 31'd999);
		send_op(OP_SWEEP, '0, '0, 31'd1500);
		send_op(OP_SWEEP, '0, '0, TIME_MAX);
		drain();
		set_life(16'hFFFF);
		for (int i = 0; i < SLOTS + 3; i++)
			send_op(OP_ALLOC, '0, 3'(i), TIME_MAX - 31'(i));
		send_op(OP_SWEEP, '0, '0, TIME_MAX);

		// receiver holds off long enough for the pool to back up
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) send_op(OP_ALLOC, '0, '0, 31'(i));
		join
		drain();

		send_gap_pct = 8;
		recv_gap_pct = 60;
		set_life(16'd0);
		clock_now = 31'd100;
		random_ops(130);
		drain();

		send_gap_pct = 60;
		recv_gap_pct = 8;
		set_life(16'd50);
		random_ops(130);
		drain();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_life(16'($urandom));
		random_ops(140);
		drain();

		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
